FILE: rtl/core/iplh_pkg.sv
package iplh_pkg;

  localparam int DEF_MAX_LEVELS = 256;
  localparam int DEF_PRICE_BITS = 12;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_PRESENT = 2'd1,
    STAT_ABSENT  = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DONE
  } state_e;

  typedef struct packed {
    logic  en;
    kind_e kind;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/iplh_cell.sv
module iplh_cell
  import iplh_pkg::*;
#(
  parameter int PRICE_BITS = DEF_PRICE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctrl_t            ctrl_i,
  input  logic [PRICE_BITS-1:0] key_i,
  input  logic                  left_valid_i,
  input  logic [PRICE_BITS-1:0] left_value_i,
  input  logic                  right_valid_i,
  input  logic [PRICE_BITS-1:0] right_value_i,
  output logic                  valid_o,
  output logic [PRICE_BITS-1:0] value_o
);

  logic                  valid_q, valid_d;
  logic [PRICE_BITS-1:0] value_q, value_d;

  // cells are kept in descending order, invalid cells at the tail
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctrl_i.en) begin
      if (ctrl_i.kind == KIND_REMOVE) begin
        if (valid_q && (value_q <= key_i)) begin
          valid_d = right_valid_i;
          value_d = right_value_i;
        end
      end else begin
        if (left_valid_i && (left_value_i < key_i)) begin
          valid_d = 1'b1;
          value_d = left_value_i;
        end else if (left_valid_i && (!valid_q || (value_q < key_i))) begin
          valid_d = 1'b1;
          value_d = key_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;

endmodule

FILE: rtl/core/indexed_price_level_heap.sv
// channel | direction | handshake              | payload
// in      | to block  | in_valid_i / in_stall_o  | kind_i, price_i
// out     | from block| out_valid_o / out_stall_i| status_o, best_price_o, is_empty_o,
//         |           |                          | level_count_o
// an item goes through accept with presence table read, then cell row update, then result load
// the row of MAX_LEVELS cells keeps the levels sorted and shifts them in parallel
// after reset a clearing pass over all 2^PRICE_BITS entries (4096 by default) clears the
// presence table; in_stall_o stays high until it ends
// a stalled result keeps the item in its final state, S_DONE, with in_stall_o high, until the
// output register frees
module indexed_price_level_heap
  import iplh_pkg::*;
#(
  parameter int MAX_LEVELS = DEF_MAX_LEVELS,
  parameter int PRICE_BITS = DEF_PRICE_BITS,
  localparam int CW = $clog2(MAX_LEVELS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  kind_i,
  input  logic [PRICE_BITS-1:0] price_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic [PRICE_BITS-1:0] best_price_o,
  output logic                  is_empty_o,
  output logic [CW-1:0]         level_count_o
);

  localparam int DEPTH = 1 << PRICE_BITS;

  state_e                state_q, state_d;
  logic [PRICE_BITS-1:0] clr_q, clr_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  kind_e                 kind_q;
  logic [PRICE_BITS-1:0] price_q;
  logic                  present_q;
  status_e               stat_q, stat_d;
  logic                  out_valid_q, out_valid_d;
  status_e               out_stat_q;
  logic [PRICE_BITS-1:0] out_best_q;
  logic                  out_empty_q;
  logic [CW-1:0]         out_cnt_q;

  logic                  present_mem [DEPTH];
  logic                  mem_we;
  logic [PRICE_BITS-1:0] mem_wa;
  logic                  mem_wd;

  logic                  accept;
  logic                  full;
  logic                  op_go;
  status_e               decide;
  logic                  out_free;
  logic                  load;
  cell_ctrl_t            cell_ctrl;
  logic [PRICE_BITS-1:0] best;

  logic                  cell_valid [MAX_LEVELS];
  logic [PRICE_BITS-1:0] cell_value [MAX_LEVELS];

  assign accept   = in_valid_i && !in_stall_o;
  assign full     = (cnt_q == CW'(MAX_LEVELS));
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    op_go  = 1'b0;
    decide = STAT_DONE;
    if (kind_q == KIND_INSERT) begin
      if (present_q) begin
        decide = STAT_PRESENT;
      end else if (full) begin
        decide = STAT_FULL;
      end else begin
        op_go = 1'b1;
      end
    end else begin
      if (present_q) begin
        op_go = 1'b1;
      end else begin
        decide = STAT_ABSENT;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == {PRICE_BITS{1'b1}}) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // outputs of the control
  always_comb begin
    in_stall_o = 1'b1;
    clr_d      = clr_q;
    cnt_d      = cnt_q;
    stat_d     = stat_q;
    mem_we     = 1'b0;
    mem_wa     = price_q;
    mem_wd     = 1'b0;
    cell_ctrl  = '{en: 1'b0, kind: kind_q};
    load       = 1'b0;
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        clr_d  = clr_q + 1'b1;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
      end
      S_READ: begin
        stat_d       = decide;
        cell_ctrl.en = op_go;
        mem_we       = op_go;
        mem_wd       = (kind_q == KIND_INSERT);
        if (op_go) begin
          cnt_d = (kind_q == KIND_INSERT) ? cnt_q + 1'b1 : cnt_q - 1'b1;
        end
      end
      S_DONE: begin
        load = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      present_mem[mem_wa] <= mem_wd;
    end
    if (accept) begin
      present_q <= present_mem[price_i];
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_LEVELS; gi++) begin : g_cell
      logic                  lv, rv;
      logic [PRICE_BITS-1:0] lval, rval;
      if (gi == 0) begin : g_head
        assign lv   = 1'b1;
        assign lval = price_q;
      end else begin : g_body
        assign lv   = cell_valid[gi-1];
        assign lval = cell_value[gi-1];
      end
      if (gi == MAX_LEVELS - 1) begin : g_tail
        assign rv   = 1'b0;
        assign rval = '0;
      end else begin : g_next
        assign rv   = cell_valid[gi+1];
        assign rval = cell_value[gi+1];
      end
      iplh_cell #(
        .PRICE_BITS(PRICE_BITS)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (cell_ctrl),
        .key_i        (price_q),
        .left_valid_i (lv),
        .left_value_i (lval),
        .right_valid_i(rv),
        .right_value_i(rval),
        .valid_o      (cell_valid[gi]),
        .value_o      (cell_value[gi])
      );
    end
  endgenerate

  assign best = cell_valid[0] ? cell_value[0] : '0;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_e'(kind_i);
      price_q <= price_i;
    end
    stat_q <= stat_d;
    if (load) begin
      out_stat_q  <= stat_q;
      out_best_q  <= best;
      out_empty_q <= (cnt_q == '0);
      out_cnt_q   <= cnt_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_stat_q;
  assign best_price_o  = out_best_q;
  assign is_empty_o    = out_empty_q;
  assign level_count_o = out_cnt_q;

endmodule

FILE: rtl/core/iplh_checker.sv
module iplh_checker
  import iplh_pkg::*;
#(
  parameter int MAX_LEVELS = DEF_MAX_LEVELS,
  parameter int PRICE_BITS = DEF_PRICE_BITS,
  localparam int CW = $clog2(MAX_LEVELS + 1)
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  kind_i,
  input logic [PRICE_BITS-1:0] price_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [1:0]            status_o,
  input logic [PRICE_BITS-1:0] best_price_o,
  input logic                  is_empty_o,
  input logic [CW-1:0]         level_count_o
);

  // a stalled transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (level_count_o == '0)))
    else $error("empty flag disagrees with count");

  a_empty_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> (best_price_o == '0))
    else $error("best price not zero when empty");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_FULL) |-> (level_count_o == CW'(MAX_LEVELS)))
    else $error("full status below capacity");

  a_present_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_PRESENT) |-> !is_empty_o)
    else $error("already present reported on empty set");

endmodule

bind indexed_price_level_heap iplh_checker #(
  .MAX_LEVELS(MAX_LEVELS),
  .PRICE_BITS(PRICE_BITS)
) u_iplh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .kind_i       (kind_i),
  .price_i      (price_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .best_price_o (best_price_o),
  .is_empty_o   (is_empty_o),
  .level_count_o(level_count_o)
);

FILE: bench/indexed_price_level_heap_tb.sv
module indexed_price_level_heap_tb;
  import iplh_pkg::*;

  localparam int LEVEL_CAP = DEF_MAX_LEVELS;
  localparam int PW = DEF_PRICE_BITS;
  localparam int PRICE_SPAN = 1 << PW;
  localparam int CW = $clog2(LEVEL_CAP + 1);

  typedef struct {
    kind_e         kind;
    logic [PW-1:0] price;
    int            gap;
  } level_op_t;

  typedef struct {
    status_e       status;
    logic [PW-1:0] best;
    logic          empty;
    logic [CW-1:0] count;
  } level_report_t;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  logic          kind_i;
  logic [PW-1:0] price_i;
  logic          out_valid_o;
  logic          out_stall_i;
  logic [1:0]    status_o;
  logic [PW-1:0] best_price_o;
  logic          is_empty_o;
  logic [CW-1:0] level_count_o;

  indexed_price_level_heap uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .price_i      (price_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .best_price_o (best_price_o),
    .is_empty_o   (is_empty_o),
    .level_count_o(level_count_o)
  );

  // stimulus and its generation-time view of the book
  level_op_t     pending_ops[$];
  logic [PW-1:0] gen_held[$];
  bit            gen_mark[PRICE_SPAN];
  int            gen_calm;

  // predicted book
  bit            book_held[PRICE_SPAN];
  int            book_total;
  level_report_t level_reports_q[$];

  int            mismatch_count;
  int            status_seen[4];
  int            peak_count;
  int            results_seen;

  level_op_t     next_op;
  bit            have_next;
  int            op_wait;
  bit            in_acc;
  bit            out_acc;
  int            out_wait;
  int            out_calm;

  always #1 clk_i = ~clk_i;

  task automatic queue_op(input kind_e k, input logic [PW-1:0] p);
    level_op_t op;
    op.kind = k;
    op.price = p;
    if (gen_calm > 0) begin
      op.gap = 0;
      gen_calm--;
    end else if ($urandom_range(0, 24) == 0) begin
      op.gap = 0;
      gen_calm = $urandom_range(10, 30);
    end else begin
      op.gap = $urandom_range(0, 17);
    end
    pending_ops.insert(pending_ops.size(), op);
    if (k == KIND_INSERT && !gen_mark[p] && gen_held.size() < LEVEL_CAP) begin
      gen_mark[p] = 1;
      gen_held.insert(gen_held.size(), p);
    end else if (k == KIND_REMOVE && gen_mark[p]) begin
      gen_mark[p] = 0;
      foreach (gen_held[i]) begin
        if (gen_held[i] == p) begin
          gen_held.delete(i);
          break;
        end
      end
    end
  endtask

  function automatic logic [PW-1:0] fresh_price();
    logic [PW-1:0] p;
    p = PW'($urandom);
    while (gen_mark[p]) p = PW'($urandom);
    return p;
  endfunction

  function automatic logic [PW-1:0] held_price();
    return gen_held[$urandom_range(0, gen_held.size() - 1)];
  endfunction

  task automatic random_mix(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 9);
      if (gen_held.size() == 0 && r >= 4 && r <= 8) r = 0;
      if (r <= 3) queue_op(KIND_INSERT, fresh_price());
      else if (r <= 5) queue_op(KIND_INSERT, held_price());
      else if (r <= 8) queue_op(KIND_REMOVE, held_price());
      else queue_op(KIND_REMOVE, PW'($urandom));
    end
  endtask

  function automatic level_report_t apply_level_op(input kind_e k, input logic [PW-1:0] p);
    level_report_t r;
    r.status = STAT_DONE;
    if (k == KIND_INSERT) begin
      if (book_held[p]) r.status = STAT_PRESENT;
      else if (book_total >= LEVEL_CAP) r.status = STAT_FULL;
      else begin
        book_held[p] = 1;
        book_total++;
      end
    end else begin
      if (!book_held[p]) r.status = STAT_ABSENT;
      else begin
        book_held[p] = 0;
        book_total--;
      end
    end
    r.best = '0;
    for (int i = PRICE_SPAN - 1; i >= 0; i--) begin
      if (book_held[i]) begin
        r.best = PW'(i);
        break;
      end
    end
    r.empty = (book_total == 0);
    r.count = CW'(book_total);
    return r;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_acc)) begin
      if (!have_next && pending_ops.size() > 0) begin
        next_op = pending_ops.pop_front();
        op_wait = next_op.gap;
        have_next = 1;
      end
      if (have_next && op_wait == 0) begin
        in_valid_i <= 1'b1;
        kind_i <= next_op.kind;
        price_i <= next_op.price;
        have_next = 0;
      end else begin
        in_valid_i <= 1'b0;
        if (have_next) op_wait--;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_acc) begin
        if (out_calm > 0) begin
          out_wait = 0;
          out_calm--;
        end else if ($urandom_range(0, 24) == 0) begin
          out_wait = 0;
          out_calm = $urandom_range(10, 30);
        end else begin
          out_wait = $urandom_range(0, 17);
        end
      end
      if (out_wait > 0) begin
        out_stall_i <= 1'b1;
        out_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_acc <= in_valid_i && !in_stall_o;
      out_acc <= out_valid_o && !out_stall_i;
      if (in_valid_i && !in_stall_o)
        level_reports_q.insert(level_reports_q.size(),
                               apply_level_op(kind_e'(kind_i), price_i));
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        status_seen[status_o]++;
        if (int'(level_count_o) > peak_count) peak_count = int'(level_count_o);
        if (level_reports_q.size() == 0) begin
          $display("%0t: unexpected transaction, status %0d best %0d count %0d",
                   $time, status_o, best_price_o, level_count_o);
          mismatch_count++;
        end else begin
          level_report_t exp_r;
          exp_r = level_reports_q.pop_front();
          if (status_o !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status_o);
            mismatch_count++;
          end
          if (best_price_o !== exp_r.best) begin
            $display("%0t: best_price expected %0d actual %0d", $time, exp_r.best,
                     best_price_o);
            mismatch_count++;
          end
          if (is_empty_o !== exp_r.empty) begin
            $display("%0t: is_empty expected %0d actual %0d", $time, exp_r.empty,
                     is_empty_o);
            mismatch_count++;
          end
          if (level_count_o !== exp_r.count) begin
            $display("%0t: level_count expected %0d actual %0d", $time, exp_r.count,
                     level_count_o);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    #1000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = 1'b0;
    price_i = '0;
    out_stall_i = 1'b0;
    have_next = 0;
    op_wait = 0;
    in_acc = 0;
    out_acc = 0;
    out_wait = 0;
    out_calm = 0;
    gen_calm = 0;
    book_total = 0;
    mismatch_count = 0;
    peak_count = 0;
    results_seen = 0;

    // directed: empty book, extremes, duplicates, absent removes, tail remove
    queue_op(KIND_REMOVE, 12'd100);
    queue_op(KIND_INSERT, 12'd0);
    queue_op(KIND_INSERT, 12'hfff);
    queue_op(KIND_INSERT, 12'd0);
    queue_op(KIND_INSERT, 12'd2048);
    queue_op(KIND_REMOVE, 12'hfff);
    queue_op(KIND_REMOVE, 12'd1234);
    queue_op(KIND_INSERT, 12'd1);
    queue_op(KIND_REMOVE, 12'd1);
    queue_op(KIND_REMOVE, 12'd0);
    queue_op(KIND_REMOVE, 12'd2048);
    queue_op(KIND_REMOVE, 12'd2048);
    queue_op(KIND_INSERT, 12'haaa);
    queue_op(KIND_INSERT, 12'h555);
    queue_op(KIND_INSERT, 12'haaa);
    queue_op(KIND_REMOVE, 12'h555);
    queue_op(KIND_REMOVE, 12'haaa);

    random_mix(80);
    // fill to capacity with some duplicates mixed in
    while (gen_held.size() < LEVEL_CAP) begin
      if ($urandom_range(0, 9) == 0) queue_op(KIND_INSERT, held_price());
      else queue_op(KIND_INSERT, fresh_price());
    end
    repeat (6) queue_op(KIND_INSERT, fresh_price());
    repeat (3) queue_op(KIND_INSERT, held_price());
    queue_op(KIND_REMOVE, held_price());
    queue_op(KIND_INSERT, fresh_price());
    queue_op(KIND_INSERT, fresh_price());
    // mostly removes
    repeat (60) begin
      if ($urandom_range(0, 4) == 0) queue_op(KIND_INSERT, fresh_price());
      else queue_op(KIND_REMOVE, held_price());
    end
    random_mix(30);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_ops.size() == 0 && !have_next && !in_valid_i);
    wait (level_reports_q.size() == 0);
    repeat (20) @(posedge clk_i);

    $display("%0d transactions checked: %0d done, %0d already present, %0d absent, %0d full",
             results_seen, status_seen[STAT_DONE], status_seen[STAT_PRESENT],
             status_seen[STAT_ABSENT], status_seen[STAT_FULL]);
    $display("peak level count %0d of %0d", peak_count, LEVEL_CAP);
    if (mismatch_count == 0 && level_reports_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/iplh_pkg.sv
rtl/core/iplh_cell.sv
rtl/core/indexed_price_level_heap.sv
rtl/core/iplh_checker.sv
bench/indexed_price_level_heap_tb.sv
